### rtl/ipv6tp_pkg.sv
// ipv6tp_pkg: widths, codes and parser state type for the IPv6 text parser
// no dependencies; used by the channel interfaces, the parser and its testbench

package ipv6tp_pkg;

  localparam int NUM_GROUPS     = 8;
  localparam int GROUP_W        = 16;
  localparam int MAX_SIG_DIGITS = 8;
  localparam int CHAR_W         = 8;
  localparam int HALF_W         = 64;

  localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;

  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [GROUP_W-1:0] group_t;
  typedef logic [HALF_W-1:0]  half_addr_t;

  typedef enum logic [1:0] {
    ERR_BAD_CHAR    = 2'd0,
    ERR_TOO_MANY    = 2'd1,
    ERR_GROUP_COUNT = 2'd2,
    ERR_TOO_LONG    = 2'd3
  } err_kind_t;

  // running state for one address text
  typedef struct packed {
    logic [3:0] group_count;
    logic       gap_seen;
    logic [3:0] gap_position;
    group_t     digit_accum;
    logic [3:0] digit_count;
    logic       colon_pending;
    logic       group_open;
    logic       error_seen;
    err_kind_t  first_error;
  } parse_state_t;

endpackage

### rtl/ipv6tp_ifs.sv
// ipv6tp_char_if and ipv6tp_addr_if: valid/ready channels of the parser
// depends on ipv6tp_pkg for payload types

interface ipv6tp_char_if;
  logic                 valid;
  logic                 ready;
  ipv6tp_pkg::char_t    text_char;
  logic                 last_char;

  modport source (output valid, output text_char, output last_char, input ready);
  modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

interface ipv6tp_addr_if;
  logic                   valid;
  logic                   ready;
  ipv6tp_pkg::half_addr_t addr_high;
  ipv6tp_pkg::half_addr_t addr_low;
  logic                   parse_ok;
  logic [1:0]             error_kind;

  modport source (output valid, output addr_high, output addr_low, output parse_ok,
                  output error_kind, input ready);
  modport sink   (input valid, input addr_high, input addr_low, input parse_ok,
                  input error_kind, output ready);
endinterface

### rtl/ipv6_address_text_parser.sv
// ipv6_address_text_parser: character-serial IPv6 text address parser
// depends on ipv6tp_pkg and the channel interfaces in ipv6tp_ifs.sv
//
//   port      dir   request                           when
//   in_char   sink  one text character, last flag     every character
//   out_addr  src   128-bit address or error code     once per text, on last
//
// one character per cycle, but a last character waits while an untaken result
// holds the output register; a character is held in the input register, and the result
// of a text is loaded into the output register at the edge where its last character
// leaves the input register; state update and gap expansion are combinational
// rst_n (synchronous) clears the valid bits and the parse state
// a stalled result only holds back a following last character; others flow

module ipv6_address_text_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  ipv6tp_char_if.sink          in_char,
  ipv6tp_addr_if.source        out_addr
);
  import ipv6tp_pkg::*;

  typedef struct packed {
    parse_state_t st;
    logic         we;
    logic [2:0]   idx;
    group_t       data;
  } close_res_t;

  function automatic close_res_t close_grp(parse_state_t s);
    close_res_t r;
    r.st   = s;
    r.we   = 1'b0;
    r.idx  = s.group_count[2:0];
    r.data = s.digit_accum;
    if (!s.error_seen && s.group_open) begin
      if (s.group_count >= 4'(NUM_GROUPS)) begin
        r.st.error_seen  = 1'b1;
        r.st.first_error = ERR_TOO_MANY;
      end else if (s.digit_count > 4'(MAX_SIG_DIGITS)) begin
        r.st.error_seen  = 1'b1;
        r.st.first_error = ERR_TOO_LONG;
      end else begin
        r.we             = 1'b1;
        r.st.group_count = s.group_count + 4'd1;
        r.st.digit_accum = '0;
        r.st.digit_count = '0;
        r.st.group_open  = 1'b0;
      end
    end
    return r;
  endfunction

  // input register
  logic         in_valid_r;
  char_t        char_r;
  logic         last_r;

  parse_state_t state_r;
  group_t       group_store [NUM_GROUPS];

  // output register
  logic         out_valid_r;
  half_addr_t   addr_high_r;
  half_addr_t   addr_low_r;
  logic         parse_ok_r;
  logic [1:0]   error_kind_r;

  logic         advance;
  logic         out_free;

  parse_state_t s1;
  parse_state_t s2;
  close_res_t   cr1;
  close_res_t   cr2;
  logic         hex_ok;
  logic [3:0]   hex_val;
  logic         store_we;
  logic [2:0]   store_idx;
  group_t       store_data;
  group_t       view [NUM_GROUPS];
  group_t       grp [NUM_GROUPS];
  logic [3:0]   src_idx [NUM_GROUPS];
  logic [3:0]   gap_pos;
  logic [3:0]   zeros;
  logic         fin_error;
  logic [1:0]   fin_kind;

  assign out_free      = !out_valid_r || out_addr.ready;
  assign advance       = in_valid_r && (!last_r || out_free);
  assign in_char.ready = !in_valid_r || advance;

  // hex digit decode
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = char_r[3:0];
    if (char_r >= "0" && char_r <= "9") begin
      hex_val = char_r[3:0];
    end else if ((char_r >= "a" && char_r <= "f") || (char_r >= "A" && char_r <= "F")) begin
      hex_val = char_r[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  // per-character update, then the closing of the open group on the last one
  always_comb begin
    s1  = state_r;
    cr1 = close_grp(state_r);
    cr1.we = 1'b0;
    if (!state_r.error_seen) begin
      if (char_r == CHAR_COLON) begin
        if (state_r.colon_pending) begin
          s1.gap_seen      = 1'b1;
          s1.gap_position  = state_r.group_count;
          s1.colon_pending = 1'b0;
        end else begin
          cr1              = close_grp(state_r);
          s1               = cr1.st;
          s1.colon_pending = 1'b1;
        end
      end else begin
        s1.colon_pending = 1'b0;
        if (!hex_ok) begin
          s1.error_seen  = 1'b1;
          s1.first_error = ERR_BAD_CHAR;
        end else begin
          s1.group_open  = 1'b1;
          s1.digit_accum = {state_r.digit_accum[GROUP_W-5:0], hex_val};
          if ((state_r.digit_count != 4'd0 || hex_val != 4'd0) &&
              state_r.digit_count <= 4'(MAX_SIG_DIGITS)) begin
            s1.digit_count = state_r.digit_count + 4'd1;
          end
        end
      end
    end
    cr2 = close_grp(s1);
    if (!last_r) begin
      cr2.we = 1'b0;
    end
    s2 = cr2.st;
    // at most one of the two closes writes in a cycle
    store_we   = cr1.we || cr2.we;
    store_idx  = cr1.we ? cr1.idx : cr2.idx;
    store_data = cr1.we ? cr1.data : cr2.data;
  end

  // gap expansion over the store, with the group closed this cycle bypassed
  always_comb begin
    gap_pos = (s2.gap_position > s2.group_count) ? s2.group_count : s2.gap_position;
    zeros   = 4'(NUM_GROUPS) - s2.group_count;
    for (int j = 0; j < NUM_GROUPS; j++) begin
      view[j]    = (store_we && store_idx == 3'(j)) ? store_data : group_store[j];
      src_idx[j] = 4'(j) - zeros;
    end
    for (int j = 0; j < NUM_GROUPS; j++) begin
      if (!s2.gap_seen || 4'(j) < gap_pos) begin
        grp[j] = view[j];
      end else if (4'(j) >= gap_pos + zeros) begin
        grp[j] = view[src_idx[j][2:0]];
      end else begin
        grp[j] = '0;
      end
    end
    fin_error = s2.error_seen || (!s2.gap_seen && s2.group_count != 4'(NUM_GROUPS));
    fin_kind  = s2.error_seen ? s2.first_error : ERR_GROUP_COUNT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_char.ready) begin
      in_valid_r <= in_char.valid;
    end
    if (in_char.ready && in_char.valid) begin
      char_r <= in_char.text_char;
      last_r <= in_char.last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= last_r ? '0 : s1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && store_we) begin
      group_store[store_idx] <= store_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_addr.ready) begin
      out_valid_r <= 1'b0;
    end
    if (advance && last_r) begin
      if (fin_error) begin
        addr_high_r  <= '0;
        addr_low_r   <= '0;
        parse_ok_r   <= 1'b0;
        error_kind_r <= fin_kind;
      end else begin
        addr_high_r  <= {grp[0], grp[1], grp[2], grp[3]};
        addr_low_r   <= {grp[4], grp[5], grp[6], grp[7]};
        parse_ok_r   <= 1'b1;
        error_kind_r <= ERR_BAD_CHAR;
      end
    end
  end

  assign out_addr.valid      = out_valid_r;
  assign out_addr.addr_high  = addr_high_r;
  assign out_addr.addr_low   = addr_low_r;
  assign out_addr.parse_ok   = parse_ok_r;
  assign out_addr.error_kind = error_kind_r;

endmodule

### dv/tb_ipv6_address_text_parser.sv
// testbench for ipv6_address_text_parser: address texts go in one character at a time,
// and each address or error code is checked against a behavioural predictor of the parser
// depends on ipv6tp_pkg, the channel interfaces in ipv6tp_ifs.sv and the parser rtl
`timescale 1ns / 100ps

module tb_ipv6_address_text_parser;
  import ipv6tp_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 10;
  localparam int RANDOM_CHARS  = 500;
  localparam int PRESSURE_HOLD = 200;
  localparam int PRESSURE_TEXTS = 12;
  localparam int DRAIN_CYCLES  = 20;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct {
    half_addr_t addr_high;
    half_addr_t addr_low;
    logic       parse_ok;
    err_kind_t  error_kind;
  } addr_result_t;

  // running parse of one text, and the addresses still owed by the block
  class ipv6_text_predictor;
    group_t       groups [NUM_GROUPS];
    int           grp_cnt;
    bit           gap_seen;
    int           gap_pos;
    group_t       acc;
    int           sig_digits;
    bit           colon_pend;
    bit           grp_open;
    bit           err_seen;
    err_kind_t    err_first;
    addr_result_t owed_addrs [$];
    int           mismatches;

    function new();
      mismatches = 0;
      clear_text();
    endfunction

    function void clear_text();
      foreach (groups[i]) groups[i] = '0;
      grp_cnt    = 0;
      gap_seen   = 0;
      gap_pos    = 0;
      acc        = '0;
      sig_digits = 0;
      colon_pend = 0;
      grp_open   = 0;
      err_seen   = 0;
      err_first  = ERR_BAD_CHAR;
    endfunction

    function void raise_error(err_kind_t kind);
      if (!err_seen) begin
        err_seen  = 1;
        err_first = kind;
      end
    endfunction

    function void close_group();
      if (err_seen || !grp_open) return;
      if (grp_cnt >= NUM_GROUPS) begin
        raise_error(ERR_TOO_MANY);
        return;
      end
      if (sig_digits > MAX_SIG_DIGITS) begin
        raise_error(ERR_TOO_LONG);
        return;
      end
      groups[grp_cnt] = acc;
      grp_cnt++;
      acc        = '0;
      sig_digits = 0;
      grp_open   = 0;
    endfunction

    function int hex_val(char_t c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
    endfunction

    function void take_char(char_t c, logic last);
      int           d;
      int           n;
      int           gp;
      int           zeros;
      group_t       g [NUM_GROUPS];
      addr_result_t res;
      if (!err_seen) begin
        if (c == CHAR_COLON) begin
          if (colon_pend) begin
            gap_seen   = 1;
            gap_pos    = grp_cnt;
            colon_pend = 0;
          end else begin
            close_group();
            colon_pend = 1;
          end
        end else begin
          d = hex_val(c);
          colon_pend = 0;
          if (d < 0) begin
            raise_error(ERR_BAD_CHAR);
          end else begin
            grp_open = 1;
            acc = {acc[GROUP_W-5:0], 4'(d)};
            // leading zeros do not count, and the count saturates just past the limit
            if ((sig_digits > 0 || d != 0) && sig_digits <= MAX_SIG_DIGITS) sig_digits++;
          end
        end
      end
      if (!last) return;

      close_group();
      foreach (g[i]) g[i] = '0;
      if (!err_seen) begin
        n = (grp_cnt > NUM_GROUPS) ? NUM_GROUPS : grp_cnt;
        if (gap_seen) begin
          gp    = (gap_pos > n) ? n : gap_pos;
          zeros = NUM_GROUPS - n;
          for (int i = 0; i < gp; i++) g[i] = groups[i];
          for (int i = gp; i < n; i++) g[(i + zeros) % NUM_GROUPS] = groups[i];
        end else if (n != NUM_GROUPS) begin
          raise_error(ERR_GROUP_COUNT);
        end else begin
          foreach (g[i]) g[i] = groups[i];
        end
      end
      if (err_seen) begin
        res.addr_high  = '0;
        res.addr_low   = '0;
        res.parse_ok   = 1'b0;
        res.error_kind = err_first;
      end else begin
        res.addr_high  = {g[0], g[1], g[2], g[3]};
        res.addr_low   = {g[4], g[5], g[6], g[7]};
        res.parse_ok   = 1'b1;
        res.error_kind = ERR_BAD_CHAR;
      end
      owed_addrs.push_back(res);
      clear_text();
    endfunction

    function void check_addr(half_addr_t hi, half_addr_t lo, logic ok, logic [1:0] kind);
      addr_result_t exp;
      if (owed_addrs.size() == 0) begin
        $error("unexpected result: addr_high %h addr_low %h parse_ok %0b error_kind %0d",
               hi, lo, ok, kind);
        mismatches++;
        return;
      end
      exp = owed_addrs.pop_front();
      if (hi !== exp.addr_high) begin
        $error("addr_high: expected %h, got %h", exp.addr_high, hi);
        mismatches++;
      end
      if (lo !== exp.addr_low) begin
        $error("addr_low: expected %h, got %h", exp.addr_low, lo);
        mismatches++;
      end
      if (ok !== exp.parse_ok) begin
        $error("parse_ok: expected %0b, got %0b", exp.parse_ok, ok);
        mismatches++;
      end
      if (kind !== exp.error_kind) begin
        $error("error_kind: expected %0d, got %0d", exp.error_kind, kind);
        mismatches++;
      end
    endfunction

    function int owed();
      return owed_addrs.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  ipv6tp_char_if char_ch ();
  ipv6tp_addr_if addr_ch ();

  ipv6_address_text_parser i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_char  (char_ch),
    .out_addr (addr_ch)
  );

  ipv6_text_predictor predictor;
  char_t              text_buf [$];
  bit                 calm;
  bit                 hold_request;
  int                 cycles;

  always #CLK_HALF clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic char_t hex_char(int v, bit upper);
    if (v < 10) return char_t'("0" + v);
    return upper ? char_t'("A" + v - 10) : char_t'("a" + v - 10);
  endfunction

  function automatic void put_group();
    int len;
    int lead_zeros;
    int r;
    bit upper;
    r = $urandom_range(0, 99);
    len = (r < 80) ? $urandom_range(1, 4) : (r < 95) ? $urandom_range(5, 8)
                                                     : $urandom_range(9, 12);
    lead_zeros = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len - 1) : 0;
    upper = $urandom_range(0, 1);
    for (int i = 0; i < len; i++)
      text_buf.push_back(hex_char((i < lead_zeros) ? 0 : $urandom_range(0, 15), upper));
  endfunction

  function automatic void put_groups(int n);
    for (int i = 0; i < n; i++) begin
      if (i > 0) text_buf.push_back(CHAR_COLON);
      put_group();
    end
  endfunction

  function automatic void load_str(string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(char_t'(s[i]));
  endfunction

  // an address of plausible shape, sometimes damaged afterwards
  function automatic void build_address();
    int total;
    int pre;
    int r;
    if ($urandom_range(0, 2) != 0) begin
      total = $urandom_range(0, 8);
      pre   = $urandom_range(0, total);
      put_groups(pre);
      text_buf.push_back(CHAR_COLON);
      text_buf.push_back(CHAR_COLON);
      put_groups(total - pre);
    end else begin
      r = $urandom_range(0, 99);
      put_groups((r < 75) ? 8 : (r < 88) ? 9 : $urandom_range(1, 7));
    end
    if ($urandom_range(0, 9) == 0)
      text_buf[$urandom_range(0, text_buf.size() - 1)] = char_t'($urandom_range(0, 255));
    if ($urandom_range(0, 14) == 0)
      text_buf.insert($urandom_range(0, text_buf.size()), CHAR_COLON);
  endfunction

  function automatic void build_noise();
    int len;
    int r;
    len = $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 2);
      if (r == 0) text_buf.push_back(CHAR_COLON);
      else if (r == 1) text_buf.push_back(hex_char($urandom_range(0, 15), $urandom_range(0, 1)));
      else text_buf.push_back(char_t'($urandom_range(0, 255)));
    end
  endfunction

  // one request per character, last flag on the final one; starts and ends at a falling edge
  task automatic send_text();
    int gap;
    for (int i = 0; i < text_buf.size(); i++) begin
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
        char_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      char_ch.valid     <= 1'b1;
      char_ch.text_char <= text_buf[i];
      char_ch.last_char <= (i == text_buf.size() - 1);
      @(posedge clk);
      while (!char_ch.ready) @(posedge clk);
      predictor.take_char(text_buf[i], i == text_buf.size() - 1);
      @(negedge clk);
    end
    text_buf.delete();
  endtask

  // result side back-pressure, with one long hold-off on request
  initial begin
    int hold_left;
    hold_left     = 0;
    addr_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 0;
        hold_left    = PRESSURE_HOLD;
      end
      if (hold_left == 0 && !calm) hold_left = pick_gap();
      if (hold_left > 0) begin
        hold_left--;
        addr_ch.ready <= 1'b0;
      end else begin
        addr_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && addr_ch.valid && addr_ch.ready)
        predictor.check_addr(addr_ch.addr_high, addr_ch.addr_low, addr_ch.parse_ok,
                             addr_ch.error_kind);
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_ipv6_address_text_parser NOT OK");
    $finish;
  end

  initial begin
    int  random_chars;
    bit  pressure_done;
    predictor         = new();
    clk               = 1'b0;
    rst_n             = 1'b0;
    calm              = 1'b0;
    hold_request      = 1'b0;
    char_ch.valid     = 1'b0;
    char_ch.text_char = '0;
    char_ch.last_char = 1'b0;
    random_chars      = 0;
    pressure_done     = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // directed: bare gap, bad char, short count, colon run, over-long group,
    // mixed case with trailing gap, and the two byte extremes
    load_str("::");        send_text();
    load_str("g");         send_text();
    load_str("1:2");       send_text();
    load_str(":::F");      send_text();
    load_str("123456789"); send_text();
    load_str("aB::");      send_text();
    text_buf.push_back(8'h00); send_text();
    text_buf.push_back(8'hFF); send_text();

    while (random_chars < RANDOM_CHARS) begin
      if ($urandom_range(0, 15) == 0) calm = !calm;
      if (!pressure_done && random_chars > RANDOM_CHARS / 2) begin
        // result side stalls while short texts keep coming, so the input backs up
        calm         = 1'b1;
        hold_request = 1'b1;
        for (int i = 0; i < PRESSURE_TEXTS; i++) begin
          load_str("1::");
          send_text();
        end
        calm          = 1'b0;
        pressure_done = 1;
      end
      if ($urandom_range(0, 9) < 8) build_address();
      else build_noise();
      random_chars += text_buf.size();
      send_text();
    end
    char_ch.valid <= 1'b0;

    while (predictor.owed() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (predictor.mismatches == 0 && predictor.owed() == 0)
      $display("tb_ipv6_address_text_parser OK");
    else
      $display("tb_ipv6_address_text_parser NOT OK");
    $finish;
  end

endmodule

### sim.f
rtl/ipv6tp_pkg.sv
rtl/ipv6tp_ifs.sv
rtl/ipv6_address_text_parser.sv
dv/tb_ipv6_address_text_parser.sv
